// ----- design/crm_pkg.sv -----
// ----------------------------------------------------------------------------
// crm_pkg: shared constants for the circular reveal mask
// Word geometry, register indexes and register reset values.
// ----------------------------------------------------------------------------
package crm_pkg;

    localparam int WORD_BITS   = 32;
    localparam int WORD_IDX_W  = $clog2(WORD_BITS);
    localparam int THR_W       = 31;

    localparam int DEF_DISP_WIDTH  = 128;
    localparam int DEF_DISP_HEIGHT = 64;

    localparam int CX_W  = 8;
    localparam int CY_W  = 7;
    localparam int CFG_INDEX_W = 2;

    localparam logic [THR_W-1:0] FULL_REVEAL = 31'h7fff_ffff;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_THRESHOLD = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_CENTER_X  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_CENTER_Y  = 2'd2;

    localparam logic [31:0]     THRESHOLD_RST = 32'hffff_ffff;
    localparam logic [CX_W-1:0] CENTER_X_RST  = 8'd64;
    localparam logic [CY_W-1:0] CENTER_Y_RST  = 7'd32;

endpackage

// ----- design/crm_lane.sv -----
// ----------------------------------------------------------------------------
// crm_lane: one pixel lane of the reveal mask
// Squares the horizontal distance of its pixel to the centre, registers it,
// then adds the vertical term and compares against the threshold.
// ----------------------------------------------------------------------------
module crm_lane
    import crm_pkg::*;
#(
    parameter int LANE  = 0,
    parameter int COL_W = 2,
    parameter int DX_W  = 9,
    parameter int DY2_W = 15,
    parameter int SUM_W = 18,
    parameter int CMP_W = 31
)
(
    input  logic              clk,
    input  logic              load,
    input  logic [COL_W-1:0]  col,
    input  logic [CX_W-1:0]   center_x,
    input  logic [DY2_W-1:0]  dy2,
    input  logic [THR_W-1:0]  thr,
    output logic              hit
);

    localparam int SQ_W = 2 * DX_W - 1;
    localparam logic [WORD_IDX_W-1:0] LANE_OFS = WORD_IDX_W'(LANE);

    logic signed [DX_W-1:0]   x_pos;
    logic signed [DX_W-1:0]   cx_pos;
    logic signed [DX_W-1:0]   dx;
    logic signed [2*DX_W-1:0] dx_prod;
    logic [SQ_W-1:0]          dx2_next;
    logic [SQ_W-1:0]          dx2_reg;
    logic [SUM_W-1:0]         dist2;

    assign x_pos    = signed'(DX_W'({col, LANE_OFS}));
    assign cx_pos   = signed'(DX_W'(center_x));
    assign dx       = x_pos - cx_pos;
    assign dx_prod  = dx * dx;
    assign dx2_next = dx_prod[SQ_W-1:0];

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            dx2_reg <= dx2_next;
        end
    end

    assign dist2 = SUM_W'(dx2_reg) + SUM_W'(dy2);
    assign hit   = CMP_W'(dist2) < CMP_W'(thr);

endmodule

// ----- design/crm_merge.sv -----
// ----------------------------------------------------------------------------
// crm_merge: lane merge and output register
// Gathers the lane hits into a mask, ANDs it with the source word and holds
// the result beat until the receiver takes it.
// ----------------------------------------------------------------------------
module crm_merge
    import crm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [WORD_BITS-1:0] hits,
    input  logic [WORD_BITS-1:0] word,
    input  logic                 last,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [WORD_BITS-1:0] m_tdata,   // pixel_word[31:0]
    output logic                 m_tlast    // frame_last
);

    logic                 valid_reg;
    logic [WORD_BITS-1:0] data_reg;
    logic [WORD_BITS-1:0] data_next;
    logic                 last_reg;
    logic [WORD_BITS-1:0] mask;

    // lane k is pixel k from the left, which sits at bit WORD_BITS-1-k
    always_comb
    begin
        for (int k = 0; k < WORD_BITS; k++)
        begin
            mask[WORD_BITS-1-k] = hits[k];
        end
    end

    assign data_next = mask & word;
    assign in_ready  = !valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
            last_reg <= last;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tlast  = last_reg;

endmodule

// ----- design/circular_reveal_mask.sv -----
// ----------------------------------------------------------------------------
// circular_reveal_mask: circular wipe over a 1-bit-per-pixel stream
// Masks each 32-pixel raster word with a disc around a configured centre.
// ----------------------------------------------------------------------------
// Usage:
//   s_tdata carries one 32-pixel word of the frame per beat, raster order,
//   MSB the leftmost pixel. m_tdata returns the word ANDed with the disc
//   (squared distance below reveal_threshold), m_tlast marks the last word
//   of the frame. The word position counts accepted beats and wraps at the
//   end of each frame.
//   Registers are written through cfg_valid/cfg_index/cfg_data; cfg_ready is
//   always high. Index 0 is the threshold (negative shows every pixel),
//   1 the centre column, 2 the centre row. Write them only while idle.
//   Throughput is one word per clock while m_tready stays high: 32 lanes
//   each square their own x distance in parallel, and the pipeline has
//   three register stages (input, squares, output). An accepted input
//   beat passes through all three before its result is on m_tvalid.
//   When the receiver stalls, the output holds and the stalls ripple back
//   stage by stage; s_tready stays high until all three stages are full.
//   Reset empties the pipeline, zeroes the position and restores the
//   register defaults (full reveal, centre 64/32).
// ----------------------------------------------------------------------------
module circular_reveal_mask
    import crm_pkg::*;
#(
    parameter int DISP_WIDTH  = DEF_DISP_WIDTH,
    parameter int DISP_HEIGHT = DEF_DISP_HEIGHT
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [WORD_BITS-1:0]   s_tdata,    // bitmap_word[31:0]
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [WORD_BITS-1:0]   m_tdata,    // pixel_word[31:0]
    output logic                   m_tlast,    // frame_last
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [31:0]            cfg_data
);

    localparam int WPR   = (DISP_WIDTH + WORD_BITS - 1) / WORD_BITS;
    localparam int COL_W = (WPR > 1) ? $clog2(WPR) : 1;
    localparam int ROW_W = (DISP_HEIGHT > 1) ? $clog2(DISP_HEIGHT) : 1;
    localparam int XW    = COL_W + WORD_IDX_W;
    localparam int DX_W  = ((XW > CX_W) ? XW : CX_W) + 1;
    localparam int SQ_W  = 2 * DX_W - 1;
    localparam int DY_W  = ((ROW_W > CY_W) ? ROW_W : CY_W) + 1;
    localparam int DY2_W = 2 * DY_W - 1;
    localparam int SUM_W = ((SQ_W > DY2_W) ? SQ_W : DY2_W) + 1;
    localparam int CMP_W = (SUM_W > THR_W) ? SUM_W : THR_W;

    localparam logic [COL_W-1:0] LAST_COL = COL_W'(WPR - 1);
    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(DISP_HEIGHT - 1);

    // configuration
    logic [31:0]      thr_reg;
    logic [CX_W-1:0]  cx_reg;
    logic [CY_W-1:0]  cy_reg;
    logic [THR_W-1:0] thr_eff;

    // position
    logic [COL_W-1:0] col_reg;
    logic [COL_W-1:0] col_next;
    logic [ROW_W-1:0] row_reg;
    logic [ROW_W-1:0] row_next;
    logic             in_beat;

    // stage 1: captured word and position
    logic                 s1_valid_reg;
    logic [WORD_BITS-1:0] s1_word_reg;
    logic [COL_W-1:0]     s1_col_reg;
    logic [ROW_W-1:0]     s1_row_reg;
    logic                 s1_last_reg;
    logic                 s1_ready;

    // stage 2: squares
    logic                 s2_valid_reg;
    logic [WORD_BITS-1:0] s2_word_reg;
    logic [DY2_W-1:0]     s2_dy2_reg;
    logic                 s2_last_reg;
    logic                 s2_ready;
    logic                 s2_load;
    logic                 out_ready;

    logic signed [DY_W-1:0]   dy;
    logic signed [2*DY_W-1:0] dy_prod;
    logic [WORD_BITS-1:0]     hits;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= THRESHOLD_RST;
            cx_reg  <= CENTER_X_RST;
            cy_reg  <= CENTER_Y_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_THRESHOLD: thr_reg <= cfg_data;
                CFG_CENTER_X:  cx_reg  <= cfg_data[CX_W-1:0];
                CFG_CENTER_Y:  cy_reg  <= cfg_data[CY_W-1:0];
                default:       ;
            endcase
        end
    end

    // negative threshold reveals everything
    assign thr_eff = thr_reg[31] ? FULL_REVEAL : thr_reg[THR_W-1:0];

    // handshake chain back from the output register
    assign s2_ready = !s2_valid_reg || out_ready;
    assign s2_load  = s1_valid_reg && s2_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign s_tready = s1_ready;
    assign in_beat  = s_tvalid && s_tready;

    always_comb
    begin
        col_next = col_reg + COL_W'(1);
        row_next = row_reg;
        if (col_reg >= LAST_COL)
        begin
            col_next = '0;
            row_next = (row_reg >= LAST_ROW) ? '0 : row_reg + ROW_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_beat)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
            if (s1_ready)
            begin
                s1_valid_reg <= s_tvalid;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            s1_word_reg <= s_tdata;
            s1_col_reg  <= col_reg;
            s1_row_reg  <= row_reg;
            s1_last_reg <= (col_reg == LAST_COL) && (row_reg == LAST_ROW);
        end
        if (s2_load)
        begin
            s2_word_reg <= s1_word_reg;
            s2_dy2_reg  <= dy_prod[DY2_W-1:0];
            s2_last_reg <= s1_last_reg;
        end
    end

    assign dy      = signed'(DY_W'(s1_row_reg)) - signed'(DY_W'(cy_reg));
    assign dy_prod = dy * dy;

    for (genvar k = 0; k < WORD_BITS; k++)
    begin : g_lane
        crm_lane #(
            .LANE  (k),
            .COL_W (COL_W),
            .DX_W  (DX_W),
            .DY2_W (DY2_W),
            .SUM_W (SUM_W),
            .CMP_W (CMP_W)
        ) u_lane (
            .clk      (clk),
            .load     (s2_load),
            .col      (s1_col_reg),
            .center_x (cx_reg),
            .dy2      (s2_dy2_reg),
            .thr      (thr_eff),
            .hit      (hits[k])
        );
    end

    crm_merge u_merge (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s2_valid_reg),
        .in_ready (out_ready),
        .hits     (hits),
        .word     (s2_word_reg),
        .last     (s2_last_reg),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

`ifndef SYNTH
    // position wraps to the frame origin after the flagged word
    a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (in_beat && col_reg == LAST_COL && row_reg == LAST_ROW)
        |=> (col_reg == '0 && row_reg == '0))
        else $error("position did not wrap at end of frame");

    // position only moves on an accepted beat
    a_pos_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !in_beat |=> ($stable(col_reg) && $stable(row_reg)))
        else $error("position moved without an input beat");

    // stage 2 holds its word while the output register is blocked
    a_s2_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid_reg && !out_ready) |=> (s2_valid_reg && $stable(s2_word_reg)))
        else $error("stage 2 lost its word during a stall");

    // input side stalls only when both inner stages and the output are full
    a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (s1_valid_reg && s2_valid_reg && m_tvalid))
        else $error("input stalled with room in the pipeline");
`endif

endmodule

// ----- dv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top: stream check of the circular reveal mask
// A directed table covers reset defaults, threshold extremes, an unmapped
// register index and off-frame centres. Phases of random words follow, each
// under a new register setting. Each result beat is checked against a typed
// row or a model of the disc mask and raster position. Both sides pause at
// random, and once the output holds off long enough to back up the input.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import crm_pkg::*;

    localparam int WORDS_PER_ROW   = (DEF_DISP_WIDTH + WORD_BITS - 1) / WORD_BITS;
    localparam int FRAME_ROWS      = DEF_DISP_HEIGHT;
    localparam int PIPE_STAGES     = 3;
    localparam int PHASES          = 8;
    localparam int WORDS_PER_PHASE = 50;
    localparam int HOLD_CYCLES     = 80;
    localparam int STALL_LIMIT     = 1000;
    localparam int DIR_ROWS        = 35;

    localparam logic [CFG_INDEX_W-1:0] CFG_UNMAPPED = 2'd3;

    typedef enum logic {STEP_WORD, STEP_REG} step_kind_t;

    typedef struct packed {
        logic [WORD_BITS-1:0] pixels;
        logic                 frame_end;
    } masked_word_t;

    typedef struct packed {
        step_kind_t           kind;
        logic [CFG_INDEX_W-1:0] reg_idx;
        logic [31:0]          value;      // register data or source word
        logic                 typed;      // expectation given in the row
        logic [WORD_BITS-1:0] exp_pixels;
        logic                 exp_last;
    } dir_step_t;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [WORD_BITS-1:0]   s_tdata   = '0;   // bitmap_word[31:0]
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [WORD_BITS-1:0]   m_tdata;          // pixel_word[31:0]
    logic                   m_tlast;          // frame_last
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [31:0]            cfg_data  = '0;

    // shadow registers and raster position
    logic signed [31:0] thr_reg = THRESHOLD_RST;
    logic [CX_W-1:0]    cx_reg  = CENTER_X_RST;
    logic [CY_W-1:0]    cy_reg  = CENTER_Y_RST;
    int                 col_pos = 0;
    int                 row_pos = 0;

    masked_word_t pixel_q[$];
    int           errors     = 0;
    bit           tail_run   = 1'b0;
    bit           tx_calm    = 1'b0;
    int           hold_asks  = 0;

    dir_step_t dir_steps [DIR_ROWS] = '{
        '{STEP_WORD, '0, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 1'b0},
        '{STEP_WORD, '0, 32'h0000_0000, 1'b1, 32'h0000_0000, 1'b0},
        '{STEP_WORD, '0, 32'h8000_0001, 1'b1, 32'h8000_0001, 1'b0},
        '{STEP_WORD, '0, 32'hA5A5_A5A5, 1'b1, 32'hA5A5_A5A5, 1'b0},
        '{STEP_REG,  CFG_THRESHOLD, 32'h0000_0000, 1'b0, '0, 1'b0},
        '{STEP_WORD, '0, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000, 1'b0},
        '{STEP_WORD, '0, 32'h5A5A_5A5A, 1'b1, 32'h0000_0000, 1'b0},
        '{STEP_REG,  CFG_THRESHOLD, 32'h7FFF_FFFF, 1'b0, '0, 1'b0},
        '{STEP_WORD, '0, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 1'b0},
        '{STEP_WORD, '0, 32'h1234_5678, 1'b1, 32'h1234_5678, 1'b0},
        '{STEP_REG,  CFG_THRESHOLD, 32'h8000_0000, 1'b0, '0, 1'b0},
        '{STEP_WORD, '0, 32'hDEAD_BEEF, 1'b1, 32'hDEAD_BEEF, 1'b0},
        // a write to the spare index must leave full reveal in place
        '{STEP_REG,  CFG_UNMAPPED,  32'h0000_0000, 1'b0, '0, 1'b0},
        '{STEP_WORD, '0, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 1'b0},
        '{STEP_REG,  CFG_CENTER_X,  32'h0000_00FF, 1'b0, '0, 1'b0},
        '{STEP_REG,  CFG_CENTER_Y,  32'h0000_007F, 1'b0, '0, 1'b0},
        '{STEP_REG,  CFG_THRESHOLD, 32'h0000_9C40, 1'b0, '0, 1'b0},
        '{STEP_WORD, '0, 32'hFFFF_FFFF, 1'b0, '0, 1'b0},
        '{STEP_WORD, '0, 32'hFFFF_FFFF, 1'b0, '0, 1'b0},
        '{STEP_WORD, '0, 32'hFFFF_FFFF, 1'b0, '0, 1'b0},
        '{STEP_WORD, '0, 32'hFFFF_FFFF, 1'b0, '0, 1'b0},
        '{STEP_REG,  CFG_CENTER_X,  32'h0000_0000, 1'b0, '0, 1'b0},
        '{STEP_REG,  CFG_CENTER_Y,  32'h0000_0000, 1'b0, '0, 1'b0},
        '{STEP_REG,  CFG_THRESHOLD, 32'h0000_0001, 1'b0, '0, 1'b0},
        '{STEP_WORD, '0, 32'hFFFF_FFFF, 1'b0, '0, 1'b0},
        '{STEP_REG,  CFG_CENTER_X,  32'h0000_0080, 1'b0, '0, 1'b0},
        '{STEP_REG,  CFG_CENTER_Y,  32'h0000_0040, 1'b0, '0, 1'b0},
        '{STEP_REG,  CFG_THRESHOLD, 32'h0000_1000, 1'b0, '0, 1'b0},
        '{STEP_WORD, '0, 32'hFFFF_FFFF, 1'b0, '0, 1'b0},
        '{STEP_WORD, '0, 32'hFFFF_FFFF, 1'b0, '0, 1'b0},
        '{STEP_WORD, '0, 32'hFFFF_FFFF, 1'b0, '0, 1'b0},
        '{STEP_WORD, '0, 32'hFFFF_FFFF, 1'b0, '0, 1'b0},
        '{STEP_REG,  CFG_CENTER_X,  32'h0000_0040, 1'b0, '0, 1'b0},
        '{STEP_REG,  CFG_CENTER_Y,  32'h0000_0020, 1'b0, '0, 1'b0},
        '{STEP_REG,  CFG_THRESHOLD, 32'hFFFF_FFFF, 1'b0, '0, 1'b0}
    };

    circular_reveal_mask dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Mask one word against the disc at the current position, then advance.
    function automatic masked_word_t reveal_word(input logic [WORD_BITS-1:0] src);
        masked_word_t res;
        longint       limit;
        longint       dx;
        longint       dy;
        logic [WORD_BITS-1:0] disc;
        int           k;
        limit = (thr_reg < 0) ? longint'(FULL_REVEAL) : longint'(thr_reg);
        dy    = longint'(row_pos) - longint'(cy_reg);
        disc  = '0;
        for (k = 0; k < WORD_BITS; k++)
        begin
            dx = longint'(col_pos) * WORD_BITS + k - longint'(cx_reg);
            if (dx * dx + dy * dy < limit)
                disc[WORD_BITS-1-k] = 1'b1;
        end
        res.pixels    = disc & src;
        res.frame_end = (col_pos == WORDS_PER_ROW - 1) && (row_pos == FRAME_ROWS - 1);
        if (col_pos >= WORDS_PER_ROW - 1)
        begin
            col_pos = 0;
            row_pos = (row_pos >= FRAME_ROWS - 1) ? 0 : row_pos + 1;
        end
        else
        begin
            col_pos++;
        end
        return res;
    endfunction

    task automatic offer_word(input logic [WORD_BITS-1:0] src, input bit typed,
                              input masked_word_t typed_beat);
        masked_word_t predicted;
        bit           taken;
        s_tvalid <= 1'b1;
        s_tdata  <= src;
        do
        begin
            @(negedge clk);
            taken = s_tready;
            @(posedge clk);
        end
        while (!taken);
        predicted = reveal_word(src);
        pixel_q.push_back(typed ? typed_beat : predicted);
        if (!tail_run && !tx_calm && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
    endtask

    // Drop the input and wait until every expected beat has come back.
    task automatic settle();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pixel_q.size() != 0);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] val);
        bit taken;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
        begin
            @(negedge clk);
            taken = cfg_ready;
            @(posedge clk);
        end
        while (!taken);
        case (idx)
            CFG_THRESHOLD: thr_reg = val;
            CFG_CENTER_X:  cx_reg  = val[CX_W-1:0];
            CFG_CENTER_Y:  cy_reg  = val[CY_W-1:0];
            default: ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin : stimulus
        masked_word_t   typed_beat;
        logic [31:0]    thr;
        logic [CX_W-1:0] cx;
        logic [CY_W-1:0] cy;
        logic [31:0]    src;
        int             radius;
        int             phase;
        int             n;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_steps[i])
        begin
            if (dir_steps[i].kind == STEP_REG)
            begin
                settle();
                write_reg(dir_steps[i].reg_idx, dir_steps[i].value);
            end
            else
            begin
                typed_beat.pixels    = dir_steps[i].exp_pixels;
                typed_beat.frame_end = dir_steps[i].exp_last;
                offer_word(dir_steps[i].value, dir_steps[i].typed, typed_beat);
            end
        end

        typed_beat = '0;
        for (phase = 0; phase < PHASES; phase++)
        begin
            settle();
            radius = $urandom_range(0, 160);
            thr    = radius * radius;
            cx     = CX_W'($urandom_range(0, 255));
            cy     = CY_W'($urandom_range(0, 127));
            case (phase)
                1:
                begin
                    cx = '0;
                    cy = '0;
                end
                2:
                begin
                    cx  = '1;
                    cy  = '1;
                    thr = 32'h7FFF_FFFF;
                end
                3:
                begin
                    cx = 8'd128;
                    cy = 7'd64;
                end
                4: thr = $urandom;
                6: thr = 32'hFFFF_FFFF;
                default: ;
            endcase
            write_reg(CFG_THRESHOLD, thr);
            write_reg(CFG_CENTER_X, {24'd0, cx});
            write_reg(CFG_CENTER_Y, {25'd0, cy});
            if (phase == 4)
                write_reg(CFG_UNMAPPED, $urandom);
            if (phase == PHASES - 1)
                tail_run = 1'b1;

            for (n = 0; n < WORDS_PER_PHASE; n++)
            begin
                if (n % 16 == 0)
                    tx_calm = ($urandom_range(0, 2) == 0);
                // long output stall while words keep coming
                if (phase == 2 && n == 8)
                    hold_asks++;
                case ($urandom_range(0, 3))
                    0: src = 32'hFFFF_FFFF;
                    1: src = $urandom & $urandom;
                    default: src = $urandom;
                endcase
                offer_word(src, 1'b0, typed_beat);
            end
        end

        settle();
        repeat (2 * PIPE_STAGES) @(posedge clk);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin : receiver
        int  hold_seen;
        int  span;
        bit  calm;
        hold_seen = 0;
        span      = 0;
        calm      = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_seen != hold_asks)
            begin
                hold_seen = hold_asks;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                m_tready <= 1'b1;
            end
            else if (!tail_run && !calm && $urandom_range(0, 4) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge clk);
                m_tready <= 1'b1;
            end
            else
            begin
                m_tready <= 1'b1;
            end
            if (span == 0)
            begin
                calm = ($urandom_range(0, 2) == 0);
                span = 40;
            end
            else
            begin
                span--;
            end
        end
    end

    // Sample on the falling edge: the beat is taken at the next rising edge.
    always @(negedge clk)
    begin : check_output
        masked_word_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pixel_q.size() == 0)
            begin
                $error("pixel beat with nothing expected: pixel_word %h frame_last %b",
                       m_tdata, m_tlast);
                errors++;
            end
            else
            begin
                want = pixel_q.pop_front();
                if (m_tdata !== want.pixels)
                begin
                    $error("pixel_word mismatch: expected %h, actual %h", want.pixels, m_tdata);
                    errors++;
                end
                if (m_tlast !== want.frame_end)
                begin
                    $error("frame_last mismatch: expected %b, actual %b",
                           want.frame_end, m_tlast);
                    errors++;
                end
            end
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(negedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Simulation FAILED");
        $finish;
    end

endmodule

// ----- circular_reveal_mask.f -----
design/crm_pkg.sv
design/crm_lane.sv
design/crm_merge.sv
design/circular_reveal_mask.sv
dv/tb_top.sv
